// File: hdl/ppp_pkg.sv
// ppp_pkg: shared types and constants of the perspective point projector
// register map, reset values, configuration and sideband structs
// no dependencies
package ppp_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int BASIS_W    = 16;
  localparam int VEC_W      = 3 * BASIS_W;
  // one basis product and the sum of three of them
  localparam int PROD_W     = DIFF_W + BASIS_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOV_NEAR = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT = 4'd7;

  localparam logic [VEC_W-1:0]      RST_RIGHT    = 48'd16384;
  localparam logic [VEC_W-1:0]      RST_UP       = 48'd70368744177664;
  localparam logic [VEC_W-1:0]      RST_FORWARD  = 48'd1073741824;
  localparam logic [CFG_DATA_W-1:0] RST_FOV_NEAR = 64'd14075681587200;
  localparam logic [CFG_DATA_W-1:0] RST_VIEWPORT = 64'd135110737600184320;

  typedef struct packed {
    logic [COORD_W-1:0]    cam_pos_x;
    logic [COORD_W-1:0]    cam_pos_y;
    logic [COORD_W-1:0]    cam_pos_z;
    logic [VEC_W-1:0]      right_vec;
    logic [VEC_W-1:0]      up_vec;
    logic [VEC_W-1:0]      fwd_vec;
    logic [CFG_DATA_W-1:0] fov_near;
    logic [CFG_DATA_W-1:0] viewport;
  } cfg_t;

  // per-request flags and depth that ride beside the divider
  typedef struct packed {
    logic               in_front;
    logic               in_view;
    logic [COORD_W-1:0] depth;
  } sb_t;

endpackage

// File: hdl/ppp_fifo.sv
// ppp_fifo: small register queue between the front and the back part
// depends on nothing outside itself
module ppp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  assign rdata_o = mem_r[rd_ptr_r];
  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

// File: hdl/ppp_front.sv
// ppp_front: camera transform and classification of each point
// origin subtract, basis dot products, near-plane test, divider operands
// depends on ppp_pkg
module ppp_front import ppp_pkg::*; #(
  parameter int BASIS_FRAC_BITS = 14,
  localparam int CW = SUM_W - BASIS_FRAC_BITS,
  localparam int PW = CW + BASIS_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg_i,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_point_x,
  input  logic [COORD_W-1:0] in_point_y,
  input  logic [COORD_W-1:0] in_point_z,
  output logic               valid_o,
  input  logic               push_ok_i,
  output logic [PW-1:0]      px_o,
  output logic [PW-1:0]      py_o,
  output logic [PW-1:0]      denx_o,
  output logic [PW-1:0]      deny_o,
  output logic               negx_o,
  output logic               negy_o,
  output sb_t                sb_o
);

  logic              adv;
  logic [3:0]        v_r;

  logic signed [DIFF_W-1:0] d_r    [3];
  logic signed [DIFF_W-1:0] d_nxt  [3];
  logic signed [PROD_W-1:0] prod_r   [9];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [CW-1:0]     c_r   [3];
  logic signed [CW-1:0]     c_nxt [3];

  logic [CW-1:0]      ax_r, ay_r, ax_nxt, ay_nxt;
  logic [PW-1:0]      denx_r, deny_r, px_r, py_r;
  logic [PW-1:0]      denx_nxt, deny_nxt, px_nxt, py_nxt;
  logic               negx_r, negy_r, front_r, front_nxt;
  logic [COORD_W-1:0] depth_r, depth_nxt;

  assign adv      = !v_r[3] || push_ok_i;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // stage 1: offset from the camera origin
  always_comb begin
    d_nxt[0] = DIFF_W'($signed(in_point_x)) - DIFF_W'($signed(cfg_i.cam_pos_x));
    d_nxt[1] = DIFF_W'($signed(in_point_y)) - DIFF_W'($signed(cfg_i.cam_pos_y));
    d_nxt[2] = DIFF_W'($signed(in_point_z)) - DIFF_W'($signed(cfg_i.cam_pos_z));
  end

  // stage 2: nine basis products
  always_comb begin
    logic [VEC_W-1:0] vec [3];
    vec[0] = cfg_i.right_vec;
    vec[1] = cfg_i.up_vec;
    vec[2] = cfg_i.fwd_vec;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_nxt[3*j+i] = PROD_W'(d_r[i]) *
                          PROD_W'($signed(vec[j][BASIS_W*i +: BASIS_W]));
      end
    end
  end

  // stage 3: dot product sums, floored to coordinate precision
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int j = 0; j < 3; j++) begin
      sum = SUM_W'(prod_r[3*j]) + SUM_W'(prod_r[3*j+1]) + SUM_W'(prod_r[3*j+2]);
      c_nxt[j] = CW'(sum >>> BASIS_FRAC_BITS);
    end
  end

  // stage 4: near test, magnitudes, divider operands
  always_comb begin
    logic signed [CW-1:0] near_e, sat_max, sat_min;
    logic [BASIS_W-1:0]   tanx, tany, vw, vh;
    near_e    = CW'($signed(cfg_i.fov_near[63:32]));
    tanx      = cfg_i.fov_near[15:0];
    tany      = cfg_i.fov_near[31:16];
    vw        = cfg_i.viewport[47:32];
    vh        = cfg_i.viewport[63:48];
    sat_max   = CW'(2147483647);
    sat_min   = -sat_max - CW'(1);
    front_nxt = (c_r[2] > near_e) && !c_r[2][CW-1] && (c_r[2] != '0) &&
                (tanx != '0) && (tany != '0);
    ax_nxt    = c_r[0][CW-1] ? CW'(-c_r[0]) : CW'(c_r[0]);
    ay_nxt    = c_r[1][CW-1] ? CW'(-c_r[1]) : CW'(c_r[1]);
    denx_nxt  = PW'(c_r[2]) * PW'(tanx);
    deny_nxt  = PW'(c_r[2]) * PW'(tany);
    px_nxt    = PW'(ax_nxt) * PW'(vw);
    py_nxt    = PW'(ay_nxt) * PW'(vh);
    if (c_r[2] > sat_max) begin
      depth_nxt = 32'h7FFF_FFFF;
    end else if (c_r[2] < sat_min) begin
      depth_nxt = 32'h8000_0000;
    end else begin
      depth_nxt = c_r[2][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r     <= d_nxt;
      prod_r  <= prod_nxt;
      c_r     <= c_nxt;
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      denx_r  <= denx_nxt;
      deny_r  <= deny_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      negx_r  <= c_r[0][CW-1];
      negy_r  <= c_r[1][CW-1];
      front_r <= front_nxt;
      depth_r <= depth_nxt;
    end
  end

  assign valid_o = v_r[3];
  assign px_o    = px_r;
  assign py_o    = py_r;
  assign denx_o  = denx_r;
  assign deny_o  = deny_r;
  assign negx_o  = negx_r;
  assign negy_o  = negy_r;

  // in view when |c| <= depth * tan on both axes
  always_comb begin
    sb_o.in_front = front_r;
    sb_o.in_view  = front_r &&
                    ((PW'(ax_r) << BASIS_FRAC_BITS) <= denx_r) &&
                    ((PW'(ay_r) << BASIS_FRAC_BITS) <= deny_r);
    sb_o.depth    = depth_r;
  end

endmodule

// File: hdl/ppp_div.sv
// ppp_div: pipelined restoring divider, one quotient bit per stage
// quotient is floored toward minus infinity and clamped to +-2^QB
// depends on nothing outside itself
module ppp_div #(
  parameter int DEN_W = 53,
  parameter int QB    = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [DEN_W-1:0]        den_i,
  input  logic [DEN_W-1:0]        hi_i,
  input  logic [QB-1:0]           lo_i,
  input  logic                    ovf_i,
  input  logic                    neg_i,
  output logic signed [QB+1:0]    quot_o
);

  logic [DEN_W-1:0] rem_r [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic             ovf_r [QB+1];
  logic             neg_r [QB+1];
  logic [QB-1:0]    lo_r  [QB];
  logic [DEN_W-1:0] den_r [QB];
  logic signed [QB+1:0] res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_i;
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_i;
      neg_r[0] <= neg_i;
      lo_r[0]  <= lo_i;
      den_r[0] <= den_i;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [DEN_W:0] t, d;
    logic           ge;
    assign t  = {rem_r[i], lo_r[i][QB-1]};
    assign d  = t - {1'b0, den_r[i]};
    // no borrow means the shifted remainder covers the divisor
    assign ge = !d[DEN_W];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? d[DEN_W-1:0] : t[DEN_W-1:0];
        q_r[i+1]   <= {q_r[i][QB-2:0], ge};
        ovf_r[i+1] <= ovf_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end

    if (i < QB - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          lo_r[i+1]  <= {lo_r[i][QB-2:0], 1'b0};
          den_r[i+1] <= den_r[i];
        end
      end
    end
  end

  // sign, clamp and round toward minus infinity
  always_comb begin
    logic [QB:0] mag;
    logic        inc;
    mag = ovf_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_r[QB]};
    inc = neg_r[QB] && !ovf_r[QB] && (rem_r[QB] != '0);
    mag = mag + (QB+1)'(inc);
    res_nxt = neg_r[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign quot_o = res_r;

endmodule

// File: hdl/ppp_back.sv
// ppp_back: perspective divide and viewport mapping
// two ppp_div lanes, flag delay line, saturation and output register
// depends on ppp_pkg and ppp_div
module ppp_back import ppp_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int BASIS_FRAC_BITS = 14,
  localparam int PW = SUM_W - BASIS_FRAC_BITS + BASIS_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  output logic               pop_o,
  input  logic [PW-1:0]      px_i,
  input  logic [PW-1:0]      py_i,
  input  logic [PW-1:0]      denx_i,
  input  logic [PW-1:0]      deny_i,
  input  logic               negx_i,
  input  logic               negy_i,
  input  sb_t                sb_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_in_front,
  output logic [COORD_W-1:0] out_pix_x,
  output logic [COORD_W-1:0] out_pix_y,
  output logic [COORD_W-1:0] out_depth,
  output logic               out_inside_view
);

  localparam int S    = COORD_FRAC_BITS + BASIS_FRAC_BITS - 1;
  localparam int NW   = PW + S;
  localparam int QB   = (COORD_FRAC_BITS + 17 > 33) ? COORD_FRAC_BITS + 17 : 33;
  localparam int QW   = QB + 2;
  localparam int HW   = NW - QB;
  localparam int CMPW = (HW > PW) ? HW : PW;
  localparam int LAT  = QB + 2;
  localparam int FW   = QW + 1;

  logic           adv;
  logic [LAT-1:0] v_r;
  sb_t            sb_r [LAT];

  logic [NW-1:0]  nx, ny;
  logic           ovfx, ovfy;
  logic signed [QW-1:0] qx, qy;

  logic                  out_valid_r;
  logic                  in_front_r, inside_r;
  logic [COORD_W-1:0]    sx_r, sy_r, depth_r, sx_nxt, sy_nxt;

  assign adv   = !out_valid_r || out_ready;
  assign pop_o = adv && q_valid_i;

  // numerator scaled by 2^S; high part at or above the divisor means clamp
  assign nx   = {px_i, {S{1'b0}}};
  assign ny   = {py_i, {S{1'b0}}};
  assign ovfx = CMPW'(nx[NW-1:QB]) >= CMPW'(denx_i);
  assign ovfy = CMPW'(ny[NW-1:QB]) >= CMPW'(deny_i);

  ppp_div #(.DEN_W(PW), .QB(QB)) u_div_x (
    .clk    (clk),
    .en     (adv),
    .den_i  (denx_i),
    .hi_i   (PW'(nx[NW-1:QB])),
    .lo_i   (nx[QB-1:0]),
    .ovf_i  (ovfx),
    .neg_i  (negx_i),
    .quot_o (qx)
  );

  ppp_div #(.DEN_W(PW), .QB(QB)) u_div_y (
    .clk    (clk),
    .en     (adv),
    .den_i  (deny_i),
    .hi_i   (PW'(ny[NW-1:QB])),
    .lo_i   (ny[QB-1:0]),
    .ovf_i  (ovfy),
    .neg_i  (negy_i),
    .quot_o (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb_i;
      for (int i = 1; i < LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // viewport centre plus offset, y flipped, saturated to 32 bits; zero when not in front
  always_comb begin
    logic signed [FW-1:0] vx_e, vy_e, vw_e, vh_e, qx_e, qy_e;
    logic signed [FW-1:0] sumx, sumy, sat_max, sat_min;
    vx_e    = FW'($signed(cfg_i.viewport[15:0]));
    vy_e    = FW'($signed(cfg_i.viewport[31:16]));
    vw_e    = $signed(FW'(cfg_i.viewport[47:32]));
    vh_e    = $signed(FW'(cfg_i.viewport[63:48]));
    qx_e    = FW'(qx);
    qy_e    = FW'(qy);
    sat_max = FW'(2147483647);
    sat_min = -sat_max - FW'(1);
    sumx = (vx_e <<< COORD_FRAC_BITS) + (vw_e <<< (COORD_FRAC_BITS - 1)) + qx_e;
    sumy = (vy_e <<< COORD_FRAC_BITS) + (vh_e <<< (COORD_FRAC_BITS - 1)) - qy_e;
    if (!sb_r[LAT-1].in_front) begin
      sx_nxt = '0;
    end else if (sumx > sat_max) begin
      sx_nxt = 32'h7FFF_FFFF;
    end else if (sumx < sat_min) begin
      sx_nxt = 32'h8000_0000;
    end else begin
      sx_nxt = sumx[COORD_W-1:0];
    end
    if (!sb_r[LAT-1].in_front) begin
      sy_nxt = '0;
    end else if (sumy > sat_max) begin
      sy_nxt = 32'h7FFF_FFFF;
    end else if (sumy < sat_min) begin
      sy_nxt = 32'h8000_0000;
    end else begin
      sy_nxt = sumy[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_front_r <= sb_r[LAT-1].in_front;
      inside_r   <= sb_r[LAT-1].in_view;
      depth_r    <= sb_r[LAT-1].depth;
      sx_r       <= sx_nxt;
      sy_r       <= sy_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_in_front    = in_front_r;
  assign out_pix_x       = sx_r;
  assign out_pix_y       = sy_r;
  assign out_depth       = depth_r;
  assign out_inside_view = inside_r;

  a_behind_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !in_front_r) |->
      (sx_r == '0) && (sy_r == '0) && !inside_r)
    else $error("point behind the near plane carries screen data");

endmodule

// File: hdl/perspective_point_projector_core.sv
// perspective_point_projector_core: top level of the point projector
// configuration registers, front part, request queue, back part
// depends on ppp_pkg, ppp_front, ppp_fifo, ppp_back
//
// Projects one Q16.16 world point per cycle to viewport pixels. A point is
// taken whenever in_ready is high; the result passes through the front
// stages, the queue, the back pipeline of the two pipelined restoring
// dividers that retire one quotient bit per stage, and the output register.
// Sustained rate is one point per cycle; when out_ready is held low the back
// pipeline holds, the four-entry queue fills and in_ready drops. Configuration
// is written through cfg_write_en/cfg_index/cfg_data; the user must write it
// only while no point is in flight, which the block itself does not enforce;
// indexes beyond 7 are ignored. Points at or behind the near plane, or with a
// zero tangent, come out with out_in_front low, zero screen coordinates and
// the depth only.
module perspective_point_projector_core import ppp_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int BASIS_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_W-1:0]    in_point_x,
  input  logic [COORD_W-1:0]    in_point_y,
  input  logic [COORD_W-1:0]    in_point_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_in_front,
  output logic [COORD_W-1:0]    out_pix_x,
  output logic [COORD_W-1:0]    out_pix_y,
  output logic [COORD_W-1:0]    out_depth,
  output logic                  out_inside_view
);

  localparam int PW     = SUM_W - BASIS_FRAC_BITS + BASIS_W;
  localparam int SB_W   = $bits(sb_t);
  localparam int FIFO_W = 4 * PW + 2 + SB_W;

  cfg_t cfg_r, cfg_nxt;

  logic          f_valid, q_full, q_empty, q_push, q_pop;
  logic [PW-1:0] f_px, f_py, f_denx, f_deny, b_px, b_py, b_denx, b_deny;
  logic          f_negx, f_negy, b_negx, b_negy;
  sb_t           f_sb, b_sb;
  logic [FIFO_W-1:0] q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ORIGIN_X: cfg_nxt.cam_pos_x = cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y: cfg_nxt.cam_pos_y = cfg_data[COORD_W-1:0];
        REG_ORIGIN_Z: cfg_nxt.cam_pos_z = cfg_data[COORD_W-1:0];
        REG_RIGHT:    cfg_nxt.right_vec = cfg_data[VEC_W-1:0];
        REG_UP:       cfg_nxt.up_vec    = cfg_data[VEC_W-1:0];
        REG_FORWARD:  cfg_nxt.fwd_vec   = cfg_data[VEC_W-1:0];
        REG_FOV_NEAR: cfg_nxt.fov_near  = cfg_data;
        REG_VIEWPORT: cfg_nxt.viewport  = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_pos_x <= '0;
      cfg_r.cam_pos_y <= '0;
      cfg_r.cam_pos_z <= '0;
      cfg_r.right_vec <= RST_RIGHT;
      cfg_r.up_vec    <= RST_UP;
      cfg_r.fwd_vec   <= RST_FORWARD;
      cfg_r.fov_near  <= RST_FOV_NEAR;
      cfg_r.viewport  <= RST_VIEWPORT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ppp_front #(.BASIS_FRAC_BITS(BASIS_FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .valid_o    (f_valid),
    .push_ok_i  (!q_full),
    .px_o       (f_px),
    .py_o       (f_py),
    .denx_o     (f_denx),
    .deny_o     (f_deny),
    .negx_o     (f_negx),
    .negy_o     (f_negy),
    .sb_o       (f_sb)
  );

  assign q_push  = f_valid && !q_full;
  assign q_wdata = {f_negx, f_negy, f_sb, f_px, f_py, f_denx, f_deny};
  assign {b_negx, b_negy, b_sb, b_px, b_py, b_denx, b_deny} = q_rdata;

  ppp_fifo #(.WIDTH(FIFO_W), .DEPTH(FIFO_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ppp_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .BASIS_FRAC_BITS (BASIS_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg_r),
    .q_valid_i       (!q_empty),
    .pop_o           (q_pop),
    .px_i            (b_px),
    .py_i            (b_py),
    .denx_i          (b_denx),
    .deny_i          (b_deny),
    .negx_i          (b_negx),
    .negy_i          (b_negy),
    .sb_i            (b_sb),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_in_front    (out_in_front),
    .out_pix_x       (out_pix_x),
    .out_pix_y       (out_pix_y),
    .out_depth       (out_depth),
    .out_inside_view (out_inside_view)
  );

endmodule
